### sv/pcd_pkg.sv
package pcd_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SYNC  = 2'd2,
    CMD_CLOSE = 2'd3
  } pcd_cmd_e;

  typedef enum logic [1:0] {
    FILL_NONE = 2'd0,
    FILL_READ = 2'd1,
    FILL_ZERO = 2'd2
  } pcd_fill_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } pcd_mark_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX,
    ST_MOD_WAIT,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_FREE_SCAN,
    ST_LCG_MUL,
    ST_LCG_ADD,
    ST_VIC_MOD,
    ST_VIC_RA,
    ST_VIC_RD,
    ST_INSERT,
    ST_EMIT,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_END
  } pcd_state_e;

  typedef enum logic [1:0] {
    PURP_LOOKUP,
    PURP_ERASE_VIC,
    PURP_INSERT,
    PURP_ERASE_CLOSE
  } pcd_purp_e;

  typedef struct packed {
    pcd_cmd_e     cmd;
    logic [9:0]   file_id;
    logic [50:0]  page_number;
    logic         full_page;
    logic         beyond_end;
  } pcd_in_t;

  typedef struct packed {
    logic [5:0]   slot;
    logic         hit;
    pcd_fill_e    fill_kind;
    logic         evicted;
    logic [9:0]   old_file;
    logic [50:0]  old_page;
    logic         write_back;
    logic         nothing;
    logic         last;
  } pcd_out_t;

  typedef struct packed {
    pcd_mark_e    mark;
    logic [9:0]   file;
    logic [50:0]  page;
    logic [5:0]   slot;
  } pcd_dir_t;

  typedef struct packed {
    logic [9:0]   file;
    logic [50:0]  page;
  } pcd_slot_t;

  localparam logic [63:0] MIX_C1     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2     = 64'hc4ceb9fe1a85ec53;
  localparam logic [31:0] LCG_MULT   = 32'd1103515245;
  localparam logic [31:0] LCG_INC    = 32'd12345;
  localparam logic [31:0] SEED_RESET = 32'h00C0FFEE;
  localparam int unsigned MIX_SHIFT  = 33;

endpackage

### sv/pcd_rem.sv
// Remainder by a power-of-two divisor: a mask, registered and ready in the cycle after start.
module pcd_rem #(
  parameter int unsigned DIV_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  logic             done_q;
  logic [DIV_W-1:0] rem_q, rem_d;

  always_comb begin
    rem_d = rem_q;
    if (start_i) begin
      rem_d = dividend_i[DIV_W-1:0] & (divisor_i - DIV_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### sv/page_cache_directory.sv
// Steps: an access hashes the key on the shared 32x32 multiplier, reduces it with a mask and
// probes the directory entry by entry; the result is then loaded into the output register. A
// miss scans the slots for a free one, writes its slot tag and probes again to insert; an eviction
// first picks a victim slot and hashes and probes the victim's key to erase it. Sync/close scan
// every slot; close also hashes and probes each closed page to erase it. One request at a time.
// Reset: slot state cleared at once, then a pass over the directory marks every entry empty.
module page_cache_directory #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned DIR_FACTOR = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pcd_pkg::pcd_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pcd_pkg::pcd_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_data_i
);
  import pcd_pkg::*;

  // SLOTS and DIR_FACTOR are powers of two, so both reductions are masks
  localparam int unsigned DIR_SIZE = SLOTS * DIR_FACTOR;
  localparam int unsigned SW       = $clog2(SLOTS);
  localparam int unsigned DW       = $clog2(DIR_SIZE);
  localparam int unsigned RW       = $clog2(DIR_SIZE + 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [DW-1:0] DIR_LAST  = DW'(DIR_SIZE - 1);

  // key = (file << 32) ^ page, with the first xor-shift folded in
  function automatic logic [63:0] premix(logic [9:0] file, logic [50:0] page);
    logic [63:0] k;
    k = {22'b0, file, 32'b0} ^ {13'b0, page};
    return k ^ (k >> MIX_SHIFT);
  endfunction

  // sequencer and request state
  pcd_state_e  state_q, state_d;
  pcd_purp_e   purp_q, purp_d;
  pcd_in_t     req_q, req_d;

  // hash datapath, shared multiplier
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mix_c;
  logic [63:0] mix_fin;
  logic [1:0]  mstep_q, mstep_d;
  logic        ph_q, ph_d;

  // probe
  logic [9:0]    pkey_file_q, pkey_file_d;
  logic [50:0]   pkey_page_q, pkey_page_d;
  logic [DW-1:0] e_q, e_d;
  logic [DW-1:0] pcnt_q, pcnt_d;
  logic          tomb_v_q, tomb_v_d;
  logic [DW-1:0] tomb_q, tomb_d;
  logic [DW-1:0] start_q, start_d;
  logic          prb_done, prb_found, prb_ins_v;
  logic [DW-1:0] prb_ins;
  logic          t_v;
  logic [DW-1:0] t_e;

  // slots
  logic [SW-1:0]    slot_q, slot_d;
  logic [SW-1:0]    sc_q, sc_d;
  logic [SLOTS-1:0] used_q, used_d;
  logic [SLOTS-1:0] dirty_q, dirty_d;
  logic             sc_match;
  pcd_out_t         sc_res;

  // results
  pcd_out_t res_q, res_d;
  pcd_out_t pend_q, pend_d;
  logic     pend_v_q, pend_v_d;
  pcd_out_t out_q, out_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;

  logic [31:0]   rs_q, rs_d;
  logic [DW-1:0] clr_q, clr_d;

  // directory memory
  pcd_dir_t      dir_mem [DIR_SIZE];
  logic          dir_we, dir_re;
  logic [DW-1:0] dir_waddr, dir_raddr;
  pcd_dir_t      dir_wdata, dir_rdata_q;

  // slot tag memory
  pcd_slot_t     slot_mem [SLOTS];
  logic          slot_we, slot_re;
  logic [SW-1:0] slot_waddr, slot_raddr;
  pcd_slot_t     slot_wdata, slot_rdata_q;

  // remainder unit, shared by the hash reduction and the victim pick
  logic          rem_start, rem_done;
  logic [63:0]   rem_dividend;
  logic [RW-1:0] rem_divisor, rem_val;

  pcd_rem #(.DIV_W(RW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // multiplier operands: 64x64 low product in three 32x32 partial products
  always_comb begin
    mix_c = ph_q ? MIX_C2 : MIX_C1;
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MIX) begin
      unique case (mstep_q)
        2'd0: begin
          mul_a = x_q[31:0];
          mul_b = mix_c[31:0];
        end
        2'd1: begin
          mul_a = x_q[31:0];
          mul_b = mix_c[63:32];
        end
        2'd2: begin
          mul_a = x_q[63:32];
          mul_b = mix_c[31:0];
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (state_q == ST_LCG_MUL) begin
      mul_a = rs_q;
      mul_b = LCG_MULT;
    end
    mix_fin = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
  end

  // probe step evaluation
  always_comb begin
    prb_done  = 1'b0;
    prb_found = 1'b0;
    prb_ins_v = 1'b0;
    prb_ins   = e_q;
    t_v       = tomb_v_q || (dir_rdata_q.mark == MARK_TOMB);
    t_e       = tomb_v_q ? tomb_q : e_q;
    unique case (dir_rdata_q.mark)
      MARK_EMPTY: begin
        prb_done  = 1'b1;
        prb_ins_v = 1'b1;
        prb_ins   = tomb_v_q ? tomb_q : e_q;
      end
      MARK_USED: begin
        if (dir_rdata_q.file == pkey_file_q && dir_rdata_q.page == pkey_page_q) begin
          prb_done  = 1'b1;
          prb_found = 1'b1;
        end
      end
      default: ;
    endcase
    if (!prb_done && pcnt_q == DIR_LAST) begin
      prb_done  = 1'b1;
      prb_ins_v = t_v;
      prb_ins   = t_e;
    end
  end

  // sync/close candidate for the slot under the scan
  always_comb begin
    sc_match = (slot_rdata_q.file == req_q.file_id) &&
               (req_q.cmd == CMD_CLOSE || dirty_q[sc_q]);
    sc_res            = '0;
    sc_res.slot       = 6'(sc_q);
    sc_res.evicted    = (req_q.cmd == CMD_CLOSE);
    sc_res.old_file   = slot_rdata_q.file;
    sc_res.old_page   = slot_rdata_q.page;
    sc_res.write_back = (req_q.cmd == CMD_SYNC) ? 1'b1 : dirty_q[sc_q];
  end

  always_comb begin
    state_d     = state_q;
    purp_d      = purp_q;
    req_d       = req_q;
    x_d         = x_q;
    acc_d       = acc_q;
    mstep_d     = mstep_q;
    ph_d        = ph_q;
    pkey_file_d = pkey_file_q;
    pkey_page_d = pkey_page_q;
    e_d         = e_q;
    pcnt_d      = pcnt_q;
    tomb_v_d    = tomb_v_q;
    tomb_d      = tomb_q;
    start_d     = start_q;
    slot_d      = slot_q;
    sc_d        = sc_q;
    used_d      = used_q;
    dirty_d     = dirty_q;
    res_d       = res_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rs_d        = rs_q;
    clr_d       = clr_q;

    dir_we       = 1'b0;
    dir_waddr    = '0;
    dir_wdata    = '0;
    dir_re       = 1'b0;
    dir_raddr    = e_q;
    slot_we      = 1'b0;
    slot_waddr   = slot_q;
    slot_wdata   = '0;
    slot_re      = 1'b0;
    slot_raddr   = sc_q;
    rem_start    = 1'b0;
    rem_dividend = x_d;
    rem_divisor  = RW'(DIR_SIZE);

    in_stall_o = (state_q != ST_IDLE);

    unique case (state_q)
      ST_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = clr_q;
        dir_wdata = '0;
        clr_d     = clr_q + DW'(1);
        if (clr_q == DIR_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          res_d = '0;
          if (in_data_i.cmd == CMD_READ || in_data_i.cmd == CMD_WRITE) begin
            x_d         = premix(in_data_i.file_id, in_data_i.page_number);
            pkey_file_d = in_data_i.file_id;
            pkey_page_d = in_data_i.page_number;
            ph_d        = 1'b0;
            mstep_d     = '0;
            purp_d      = PURP_LOOKUP;
            state_d     = ST_MIX;
          end else begin
            sc_d     = '0;
            pend_v_d = 1'b0;
            state_d  = ST_SC_RD;
          end
        end
      end

      ST_MIX: begin
        mstep_d = mstep_q + 2'd1;
        unique case (mstep_q)
          2'd1: acc_d = prod_q;
          2'd2: acc_d[63:32] = acc_q[63:32] + prod_q[31:0];
          2'd3: begin
            x_d = mix_fin ^ (mix_fin >> MIX_SHIFT);
            if (!ph_q) begin
              ph_d = 1'b1;
            end else begin
              rem_start    = 1'b1;
              rem_dividend = x_d;
              state_d      = ST_MOD_WAIT;
            end
          end
          default: ;
        endcase
      end

      ST_MOD_WAIT: begin
        if (rem_done) begin
          e_d      = rem_val[DW-1:0];
          pcnt_d   = '0;
          tomb_v_d = 1'b0;
          if (purp_q == PURP_LOOKUP) begin
            start_d = rem_val[DW-1:0];
          end
          state_d = ST_PRB_RD;
        end
      end

      ST_PRB_RD: begin
        dir_re    = 1'b1;
        dir_raddr = e_q;
        state_d   = ST_PRB_CHK;
      end

      ST_PRB_CHK: begin
        if (!prb_done) begin
          tomb_v_d = t_v;
          tomb_d   = t_e;
          e_d      = (e_q == DIR_LAST) ? '0 : e_q + DW'(1);
          pcnt_d   = pcnt_q + DW'(1);
          state_d  = ST_PRB_RD;
        end else begin
          unique case (purp_q)
            PURP_LOOKUP: begin
              if (prb_found) begin
                if (req_q.cmd == CMD_WRITE) begin
                  dirty_d[dir_rdata_q.slot[SW-1:0]] = 1'b1;
                end
                res_d      = '0;
                res_d.slot = 6'(dir_rdata_q.slot[SW-1:0]);
                res_d.hit  = 1'b1;
                res_d.last = 1'b1;
                state_d    = ST_EMIT;
              end else begin
                slot_d  = '0;
                state_d = ST_FREE_SCAN;
              end
            end
            PURP_ERASE_VIC, PURP_ERASE_CLOSE: begin
              if (prb_found) begin
                dir_we         = 1'b1;
                dir_waddr      = e_q;
                dir_wdata      = dir_rdata_q;
                dir_wdata.mark = MARK_TOMB;
              end
              if (purp_q == PURP_ERASE_VIC) begin
                state_d = ST_INSERT;
              end else begin
                sc_d    = sc_q + SW'(1);
                state_d = (sc_q == SLOT_LAST) ? ST_SC_END : ST_SC_RD;
              end
            end
            PURP_INSERT: begin
              if (prb_ins_v) begin
                dir_we    = 1'b1;
                dir_waddr = prb_ins;
                dir_wdata = '{mark: MARK_USED, file: req_q.file_id,
                              page: req_q.page_number, slot: 6'(slot_q)};
              end
              state_d = ST_EMIT;
            end
            default: ;
          endcase
        end
      end

      ST_FREE_SCAN: begin
        if (!used_q[slot_q]) begin
          state_d = ST_INSERT;
        end else if (slot_q == SLOT_LAST) begin
          state_d = ST_LCG_MUL;
        end else begin
          slot_d = slot_q + SW'(1);
        end
      end

      ST_LCG_MUL: begin
        state_d = ST_LCG_ADD;
      end

      ST_LCG_ADD: begin
        rs_d         = prod_q[31:0] + LCG_INC;
        rem_start    = 1'b1;
        rem_dividend = {32'b0, rs_d};
        rem_divisor  = RW'(SLOTS);
        state_d      = ST_VIC_MOD;
      end

      ST_VIC_MOD: begin
        if (rem_done) begin
          slot_d  = rem_val[SW-1:0];
          state_d = ST_VIC_RA;
        end
      end

      ST_VIC_RA: begin
        slot_re    = 1'b1;
        slot_raddr = slot_q;
        state_d    = ST_VIC_RD;
      end

      ST_VIC_RD: begin
        res_d.evicted    = 1'b1;
        res_d.old_file   = slot_rdata_q.file;
        res_d.old_page   = slot_rdata_q.page;
        res_d.write_back = dirty_q[slot_q];
        x_d              = premix(slot_rdata_q.file, slot_rdata_q.page);
        pkey_file_d      = slot_rdata_q.file;
        pkey_page_d      = slot_rdata_q.page;
        ph_d             = 1'b0;
        mstep_d          = '0;
        purp_d           = PURP_ERASE_VIC;
        state_d          = ST_MIX;
      end

      ST_INSERT: begin
        used_d[slot_q]  = 1'b1;
        dirty_d[slot_q] = (req_q.cmd == CMD_WRITE);
        slot_we         = 1'b1;
        slot_waddr      = slot_q;
        slot_wdata      = '{file: req_q.file_id, page: req_q.page_number};
        res_d.slot      = 6'(slot_q);
        res_d.hit       = 1'b0;
        res_d.last      = 1'b1;
        if (req_q.cmd == CMD_WRITE && req_q.full_page) begin
          res_d.fill_kind = FILL_NONE;
        end else begin
          res_d.fill_kind = req_q.beyond_end ? FILL_ZERO : FILL_READ;
        end
        pkey_file_d = req_q.file_id;
        pkey_page_d = req_q.page_number;
        e_d         = start_q;
        pcnt_d      = '0;
        tomb_v_d    = 1'b0;
        purp_d      = PURP_INSERT;
        state_d     = ST_PRB_RD;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_SC_RD: begin
        if (used_q[sc_q]) begin
          slot_re    = 1'b1;
          slot_raddr = sc_q;
          state_d    = ST_SC_CHK;
        end else begin
          sc_d    = sc_q + SW'(1);
          state_d = (sc_q == SLOT_LAST) ? ST_SC_END : ST_SC_RD;
        end
      end

      ST_SC_CHK: begin
        if (!sc_match) begin
          sc_d    = sc_q + SW'(1);
          state_d = (sc_q == SLOT_LAST) ? ST_SC_END : ST_SC_RD;
        end else if (!pend_v_q || out_free) begin
          // older match goes out now, this one waits so last can be marked
          if (pend_v_q) begin
            out_d       = pend_q;
            out_valid_d = 1'b1;
          end
          pend_d        = sc_res;
          pend_v_d      = 1'b1;
          dirty_d[sc_q] = 1'b0;
          if (req_q.cmd == CMD_CLOSE) begin
            used_d[sc_q] = 1'b0;
            x_d          = premix(slot_rdata_q.file, slot_rdata_q.page);
            pkey_file_d  = slot_rdata_q.file;
            pkey_page_d  = slot_rdata_q.page;
            ph_d         = 1'b0;
            mstep_d      = '0;
            purp_d       = PURP_ERASE_CLOSE;
            state_d      = ST_MIX;
          end else begin
            sc_d    = sc_q + SW'(1);
            state_d = (sc_q == SLOT_LAST) ? ST_SC_END : ST_SC_RD;
          end
        end
      end

      ST_SC_END: begin
        if (out_free) begin
          if (pend_v_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d         = '0;
            out_d.nothing = 1'b1;
            out_d.last    = 1'b1;
          end
          out_valid_d = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // seed write also reloads the generator
    if (cfg_valid_i) begin
      rs_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
      tomb_v_q    <= 1'b0;
      rs_q        <= SEED_RESET;
      purp_q      <= PURP_LOOKUP;
      mstep_q     <= '0;
      ph_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      used_q      <= used_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      pend_v_q    <= pend_v_d;
      tomb_v_q    <= tomb_v_d;
      rs_q        <= rs_d;
      purp_q      <= purp_d;
      mstep_q     <= mstep_d;
      ph_q        <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    x_q         <= x_d;
    acc_q       <= acc_d;
    prod_q      <= {32'b0, mul_a} * {32'b0, mul_b};
    pkey_file_q <= pkey_file_d;
    pkey_page_q <= pkey_page_d;
    e_q         <= e_d;
    pcnt_q      <= pcnt_d;
    tomb_q      <= tomb_d;
    start_q     <= start_d;
    slot_q      <= slot_d;
    sc_q        <= sc_d;
    res_q       <= res_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_rdata_q <= dir_mem[dir_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata_q <= slot_mem[slot_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_no_match_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.nothing |-> out_data_o.last)
    else $error("no-match result without last");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |->
      out_data_o.fill_kind == FILL_NONE && !out_data_o.evicted)
    else $error("hit result carries fill or eviction");

  a_rem_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> state_q == ST_MOD_WAIT || state_q == ST_VIC_MOD)
    else $error("remainder finished outside a wait state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted transfer not started");
`endif

endmodule
